### rtl/rgb_to_hsl_converter_top_defines.svh
// Assertion macros used by the converter top RTL.
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define RGBHSL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define RGBHSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rgbhsl_pkg.sv
// Package: payload types and fixed widths of the RGB to HSL converter.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

	// channel byte width and fixed-point result width
	localparam int CW = 8;
	localparam int QW = 16;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [QW-1:0] hue;
		logic [QW-1:0] saturation;
		logic [QW-1:0] lightness;
	} hsl_t;

endpackage

`default_nettype wire

### rtl/rgbhsl_stream_if.sv
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface rgbhsl_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/rgbhsl_div.sv
// Pipelined restoring divider: one quotient bit per stage, QW stages.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div #(
	parameter int DW = 8
) (
	input  logic                      clk,
	input  logic [rgbhsl_pkg::QW-1:0] en,
	input  logic [DW-1:0]             divisor,
	input  logic [DW-1:0]             rem_in,
	input  logic [rgbhsl_pkg::QW-1:0] lo_in,
	output logic [rgbhsl_pkg::QW-1:0] quot
);
	import rgbhsl_pkg::*;

	// rem_in must be below divisor, so the quotient fits in QW bits
	logic [DW-1:0] rem_s [QW-1];
	logic [QW-1:0] lo_s  [QW-1];
	logic [DW-1:0] d_s   [QW-1];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [DW-1:0] d_i;
		logic [QW-1:0] lo_i;
		logic [QW-1:0] q_i;
		logic [DW:0]   trial;
		logic          ge;

		// stage inputs: ports for the first stage, previous stage otherwise
		if (k == 0) begin : g_first
			assign rem_i = rem_in;
			assign d_i   = divisor;
			assign lo_i  = lo_in;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign d_i   = d_s[k-1];
			assign lo_i  = lo_s[k-1];
			assign q_i   = q_s[k-1];
		end

		// bring down one dividend bit, compare and subtract
		assign trial = {rem_i, lo_i[QW-1]};
		assign ge    = (trial >= {1'b0, d_i});

		always_ff @(posedge clk) begin
			if (en[k]) begin
				q_s[k] <= {q_i[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? DW'(trial - {1'b0, d_i}) : trial[DW-1:0];
					lo_s[k]  <= {lo_i[QW-2:0], 1'b0};
					d_s[k]   <= d_i;
				end
			end
		end
	end

	assign quot = q_s[QW-1];

endmodule

`default_nettype wire

### rtl/rgb_to_hsl_converter_top.sv
// Pipeline: 2 front stages, then 16 divider stages, from an input transfer to its result.
// Throughput: one pixel per cycle unless the output stalls; each divider stage resolves one quotient bit.
// Stages advance independently: a stalled output blocks the input only once every stage is full.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
// Hue and saturation come from two 16-stage dividers, lightness from (M+m)*257/2.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsl_converter_top_defines.svh"

module rgb_to_hsl_converter_top (
	input  logic            clk,
	input  logic            arst_n,
	rgbhsl_stream_if.sink   rgb,
	rgbhsl_stream_if.source hsl
);
	import rgbhsl_pkg::*;

	// stage valid bits and advance enables
	logic          v_s1, v_s2;
	logic [QW-1:0] v_div;
	logic          en_s1, en_s2;
	logic [QW-1:0] en_div;

	always_comb begin
		en_div[QW-1] = !v_div[QW-1] || hsl.ready;
		for (int k = QW - 2; k >= 0; k--) begin
			en_div[k] = !v_div[k] || en_div[k+1];
		end
		en_s2 = !v_s2 || en_div[0];
		en_s1 = !v_s1 || en_s2;
	end

	assign rgb.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_div <= '0;
		end else begin
			if (en_s1) begin
				v_s1 <= rgb.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_div[0]) begin
				v_div[0] <= v_s2;
			end
			for (int k = 1; k < QW; k++) begin
				if (en_div[k]) begin
					v_div[k] <= v_div[k-1];
				end
			end
		end
	end

	// stage 1: max, min and sector flags
	logic [CW-1:0] r_in, g_in, b_in;
	logic [CW-1:0] hi_w, lo_w;

	assign r_in = rgb.data.red;
	assign g_in = rgb.data.green;
	assign b_in = rgb.data.blue;

	always_comb begin
		hi_w = r_in;
		lo_w = r_in;
		if (g_in > hi_w) hi_w = g_in;
		if (b_in > hi_w) hi_w = b_in;
		if (g_in < lo_w) lo_w = g_in;
		if (b_in < lo_w) lo_w = b_in;
	end

	logic [CW-1:0] r_s1, g_s1, b_s1, hi_s1, lo_s1;
	logic          rmax_s1, gtb_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1    <= r_in;
			g_s1    <= g_in;
			b_s1    <= b_in;
			hi_s1   <= hi_w;
			lo_s1   <= lo_w;
			rmax_s1 <= (r_in > g_in) && (r_in > b_in);
			gtb_s1  <= (g_in > b_in);
		end
	end

	// stage 2: delta, sum, divider operands and lightness
	logic [CW-1:0] d_w;
	logic [CW:0]   sum_w;
	logic [CW:0]   den_w;
	logic [11:0]   d6_w;
	logic [11:0]   num_w;
	logic          grey_w;
	logic [16:0]   light_w;
	logic [23:0]   satx_w;

	assign d_w    = hi_s1 - lo_s1;
	assign sum_w  = {1'b0, hi_s1} + {1'b0, lo_s1};
	assign den_w  = (sum_w > 9'd255) ? 9'(9'd510 - sum_w) : sum_w;
	assign d6_w   = 12'(d_w) * 12'd6;
	assign grey_w = (d_w == '0);

	always_comb begin
		if (rmax_s1) begin
			num_w = 12'(g_s1) + ((g_s1 < b_s1) ? d6_w : 12'd0) - 12'(b_s1);
		end else if (gtb_s1) begin
			num_w = 12'(b_s1) + 12'({d_w, 1'b0}) - 12'(r_s1);
		end else begin
			num_w = 12'(r_s1) + 12'({d_w, 2'b0}) - 12'(g_s1);
		end
	end

	// (M+m)*65535/510 reduces exactly to (M+m)*257/2
	assign light_w = 17'({sum_w, 8'b0}) + 17'(sum_w);
	// d*65535 as d*65536 - d
	assign satx_w  = 24'({d_w, 16'b0}) - 24'(d_w);

	logic [CW-1:0] den_s2, sathi_s2;
	logic [QW-1:0] satlo_s2, light_s2;
	logic [10:0]   num_s2, d6_s2;

	// grey pixel: divisor 1 over a zero dividend gives a zero quotient
	always_ff @(posedge clk) begin
		if (en_s2) begin
			den_s2   <= grey_w ? 8'd1 : den_w[CW-1:0];
			d6_s2    <= grey_w ? 11'd1 : d6_w[10:0];
			num_s2   <= num_w[10:0];
			sathi_s2 <= satx_w[23:16];
			satlo_s2 <= satx_w[15:0];
			light_s2 <= light_w[16:1];
		end
	end

	// dividers
	logic [QW-1:0] hue_quot, sat_quot;

	rgbhsl_div #(.DW(11)) u_hue_div (
		.clk     (clk),
		.en      (en_div),
		.divisor (d6_s2),
		.rem_in  (num_s2),
		.lo_in   ('0),
		.quot    (hue_quot)
	);

	rgbhsl_div #(.DW(8)) u_sat_div (
		.clk     (clk),
		.en      (en_div),
		.divisor (den_s2),
		.rem_in  (sathi_s2),
		.lo_in   (satlo_s2),
		.quot    (sat_quot)
	);

	// lightness rides alongside the divider stages
	logic [QW-1:0] light_s [QW];

	always_ff @(posedge clk) begin
		if (en_div[0]) begin
			light_s[0] <= light_s2;
		end
		for (int k = 1; k < QW; k++) begin
			if (en_div[k]) begin
				light_s[k] <= light_s[k-1];
			end
		end
	end

	// result
	assign hsl.valid           = v_div[QW-1];
	assign hsl.data.hue        = hue_quot;
	assign hsl.data.saturation = sat_quot;
	assign hsl.data.lightness  = light_s[QW-1];

	// checks
	`RGBHSL_ASSERT_IMPL(a_stall_only_full, !rgb.ready, v_s1 && v_s2 && (&v_div),
		"input stalled while a pipeline stage is empty")
	`RGBHSL_ASSERT_NEXT(a_transfer_lands, rgb.valid && rgb.ready, v_s1,
		"input transfer did not reach stage 1")
	`RGBHSL_ASSERT_IMPL(a_hue_fits, v_s2, (d6_s2 != 11'd0) && (num_s2 < d6_s2),
		"hue dividend not below divisor")
	`RGBHSL_ASSERT_IMPL(a_sat_fits, v_s2, (den_s2 != 8'd0) && (sathi_s2 < den_s2),
		"saturation quotient would overflow")

endmodule

`default_nettype wire
